/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the type signature validator.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tsv_pkg.sv */
// Package for the type signature validator: type codes, frame kinds,
// status codes and sequencer states. No dependencies.
package tsv_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int DEPTH_W         = 6;
  localparam int FRAME_W         = 4;

  typedef enum logic [1:0] {
    ST_PENDING = 2'd0,
    ST_TYPE    = 2'd1,
    ST_ERROR   = 2'd2,
    ST_ACCEPT  = 2'd3
  } status_t;

  typedef enum logic [FRAME_W-1:0] {
    FR_ARRAY        = 4'd0,
    FR_STRUCT_EMPTY = 4'd1,
    FR_STRUCT_SOME  = 4'd2,
    FR_DICT_NONE    = 4'd3,
    FR_DICT_ONE     = 4'd4,
    FR_DICT_TWO     = 4'd5
  } frame_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CPL,
    S_WAIT,
    S_FIN
  } state_t;

  // Container codes
  localparam logic [7:0] CH_ARRAY  = 8'h61; // a
  localparam logic [7:0] CH_LPAREN = 8'h28; // (
  localparam logic [7:0] CH_RPAREN = 8'h29; // )
  localparam logic [7:0] CH_LBRACE = 8'h7B; // {
  localparam logic [7:0] CH_RBRACE = 8'h7D; // }

  // Basic codes
  localparam logic [7:0] CH_BYTE    = 8'h79; // y
  localparam logic [7:0] CH_BOOL    = 8'h62; // b
  localparam logic [7:0] CH_INT16   = 8'h6E; // n
  localparam logic [7:0] CH_UINT16  = 8'h71; // q
  localparam logic [7:0] CH_INT32   = 8'h69; // i
  localparam logic [7:0] CH_UINT32  = 8'h75; // u
  localparam logic [7:0] CH_INT64   = 8'h78; // x
  localparam logic [7:0] CH_UINT64  = 8'h74; // t
  localparam logic [7:0] CH_DOUBLE  = 8'h64; // d
  localparam logic [7:0] CH_STRING  = 8'h73; // s
  localparam logic [7:0] CH_OBJPATH = 8'h6F; // o
  localparam logic [7:0] CH_SIG     = 8'h67; // g
  localparam logic [7:0] CH_VARIANT = 8'h76; // v

  function automatic logic is_basic(input logic [7:0] c);
    logic res;
    res = 1'b0;
    case (c) inside
      CH_BYTE, CH_BOOL, CH_INT16, CH_UINT16, CH_INT32, CH_UINT32, CH_INT64,
      CH_UINT64, CH_DOUBLE, CH_STRING, CH_OBJPATH, CH_SIG, CH_VARIANT: res = 1'b1;
      default: res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

/* hdl/type_signature_validator.sv */
// The result is registered from S_EXEC for an opener, a misplaced character or a character
// ignored under a held error; a basic code or a closer goes on to S_CPL, and a closer that
// leaves frames open first passes S_WAIT for the RAM read; each further array popped passes
// S_WAIT again (one RAM read) unless it empties the stack; a busy output holds it in S_FIN.
// in_stall is high outside S_IDLE, so a new character is taken only once the result of the
// last one has gone to the output register. Reset (rst_n, synchronous,
// active low) empties the stack and clears the error.
module type_signature_validator #(
  parameter int STACK_DEPTH = tsv_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_sig_char,
  input  logic       in_end_of_signature,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [5:0] out_open_depth
);

`include "assert_macros.svh"

  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = tsv_pkg::DEPTH_W;
  localparam int FW = tsv_pkg::FRAME_W;

  // Sequencer and stack state
  tsv_pkg::state_t  state_r, state_nxt;
  logic [LW-1:0]    level_r, level_nxt;
  logic             err_r, err_nxt;
  tsv_pkg::frame_t  top_r, top_nxt;   // copy of the innermost frame
  logic [7:0]       char_r, char_nxt;
  logic             last_r, last_nxt;
  tsv_pkg::status_t status_r, status_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  tsv_pkg::status_t out_status_r, out_status_nxt;
  logic [DW-1:0]    out_depth_r, out_depth_nxt;

  // Frame stack RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [FW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [FW-1:0] ram_rdata;

  logic             out_free;
  logic             done;
  tsv_pkg::status_t done_status;
  tsv_pkg::frame_t  open_kind;
  logic             has_top;

  tsv_ram #(
    .WIDTH (FW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall       = (state_r != tsv_pkg::S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_open_depth = out_depth_r;
  assign out_free       = !out_valid_r || !out_stall;
  assign has_top        = (level_r != '0);

  // Frame kind opened by a container code
  always_comb begin
    case (char_r)
      tsv_pkg::CH_LPAREN: open_kind = tsv_pkg::FR_STRUCT_EMPTY;
      tsv_pkg::CH_LBRACE: open_kind = tsv_pkg::FR_DICT_NONE;
      default:            open_kind = tsv_pkg::FR_ARRAY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsv_pkg::S_IDLE;
      level_r     <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r        <= top_nxt;
    char_r       <= char_nxt;
    last_r       <= last_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_depth_r  <= out_depth_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    level_nxt      = level_r;
    err_nxt        = err_r;
    top_nxt        = top_r;
    char_nxt       = char_r;
    last_nxt       = last_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_depth_nxt  = out_depth_r;
    ram_we         = 1'b0;
    ram_waddr      = AW'(level_r);
    ram_wdata      = FW'(open_kind);
    // A pop always reads the frame that becomes innermost
    ram_raddr      = AW'(level_r - LW'(2));
    done           = 1'b0;
    done_status    = tsv_pkg::ST_PENDING;

    // Drop the held result once it has been taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      tsv_pkg::S_IDLE: begin
        if (in_valid) begin
          char_nxt  = in_sig_char;
          last_nxt  = in_end_of_signature;
          state_nxt = tsv_pkg::S_EXEC;
        end
      end

      tsv_pkg::S_EXEC: begin
        if (err_r) begin
          // Sticky error: ignore the character, hold the depth
          done        = 1'b1;
          done_status = tsv_pkg::ST_ERROR;
        end else if (has_top && top_r == tsv_pkg::FR_DICT_TWO &&
                     char_r != tsv_pkg::CH_RBRACE) begin
          err_nxt     = 1'b1;
          done        = 1'b1;
          done_status = tsv_pkg::ST_ERROR;
        end else if (tsv_pkg::is_basic(char_r)) begin
          state_nxt = tsv_pkg::S_CPL;
        end else begin
          case (char_r)
            tsv_pkg::CH_ARRAY, tsv_pkg::CH_LPAREN, tsv_pkg::CH_LBRACE: begin
              done = 1'b1;
              if (level_r >= LW'(STACK_DEPTH)) begin
                err_nxt     = 1'b1;
                done_status = tsv_pkg::ST_ERROR;
              end else begin
                ram_we      = 1'b1;
                top_nxt     = open_kind;
                level_nxt   = level_r + LW'(1);
                done_status = tsv_pkg::ST_PENDING;
              end
            end
            tsv_pkg::CH_RPAREN: begin
              if (has_top && top_r == tsv_pkg::FR_STRUCT_SOME) begin
                level_nxt = level_r - LW'(1);
                state_nxt = (level_r > LW'(1)) ? tsv_pkg::S_WAIT : tsv_pkg::S_CPL;
              end else begin
                err_nxt     = 1'b1;
                done        = 1'b1;
                done_status = tsv_pkg::ST_ERROR;
              end
            end
            tsv_pkg::CH_RBRACE: begin
              if (has_top && top_r == tsv_pkg::FR_DICT_TWO) begin
                level_nxt = level_r - LW'(1);
                state_nxt = (level_r > LW'(1)) ? tsv_pkg::S_WAIT : tsv_pkg::S_CPL;
              end else begin
                err_nxt     = 1'b1;
                done        = 1'b1;
                done_status = tsv_pkg::ST_ERROR;
              end
            end
            default: begin
              err_nxt     = 1'b1;
              done        = 1'b1;
              done_status = tsv_pkg::ST_ERROR;
            end
          endcase
        end
      end

      // One step of type completion on the innermost frame
      tsv_pkg::S_CPL: begin
        ram_waddr = AW'(level_r - LW'(1));
        if (!has_top) begin
          done        = 1'b1;
          done_status = tsv_pkg::ST_TYPE;
        end else begin
          case (top_r)
            tsv_pkg::FR_ARRAY: begin
              // Finished array: pop and keep cascading
              level_nxt = level_r - LW'(1);
              state_nxt = (level_r > LW'(1)) ? tsv_pkg::S_WAIT : tsv_pkg::S_CPL;
            end
            tsv_pkg::FR_STRUCT_EMPTY: begin
              ram_we    = 1'b1;
              ram_wdata = FW'(tsv_pkg::FR_STRUCT_SOME);
              top_nxt   = tsv_pkg::FR_STRUCT_SOME;
              done      = 1'b1;
            end
            tsv_pkg::FR_DICT_NONE: begin
              ram_we    = 1'b1;
              ram_wdata = FW'(tsv_pkg::FR_DICT_ONE);
              top_nxt   = tsv_pkg::FR_DICT_ONE;
              done      = 1'b1;
            end
            tsv_pkg::FR_DICT_ONE: begin
              ram_we    = 1'b1;
              ram_wdata = FW'(tsv_pkg::FR_DICT_TWO);
              top_nxt   = tsv_pkg::FR_DICT_TWO;
              done      = 1'b1;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end

      // RAM read data now holds the new innermost frame
      tsv_pkg::S_WAIT: begin
        top_nxt   = tsv_pkg::frame_t'(ram_rdata);
        state_nxt = tsv_pkg::S_CPL;
      end

      tsv_pkg::S_FIN: begin
        done        = 1'b1;
        done_status = status_r;
      end

      default: begin
        state_nxt = tsv_pkg::S_IDLE;
      end
    endcase

    // Hand the result to the output register, or hold it until free
    if (done) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_depth_nxt = DW'(level_nxt);
        if (last_r) begin
          out_status_nxt = (err_nxt || level_nxt != '0) ? tsv_pkg::ST_ERROR
                                                        : tsv_pkg::ST_ACCEPT;
          level_nxt      = '0;
          err_nxt        = 1'b0;
        end else begin
          out_status_nxt = done_status;
        end
        state_nxt = tsv_pkg::S_IDLE;
      end else begin
        status_nxt = done_status;
        state_nxt  = tsv_pkg::S_FIN;
      end
    end
  end

  `ASSERT_CLK(a_level_bound, clk, rst_n, level_r <= LW'(STACK_DEPTH),
    "stack level beyond depth")
  `ASSERT_CLK(a_accept_empty, clk, rst_n,
    !(out_valid_r && out_status_r == tsv_pkg::ST_ACCEPT) || out_depth_r == '0,
    "accepted signature with open containers")
  `ASSERT_CLK(a_wait_nonempty, clk, rst_n,
    state_r != tsv_pkg::S_WAIT || level_r != '0,
    "stack read with nothing left open")
  `ASSERT_NEXT(a_sticky_hold, clk, rst_n,
    state_r == tsv_pkg::S_EXEC && err_r && !last_r, $stable(level_r),
    "depth moved while error is set")

endmodule

/* hdl/tsv_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsv_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* dv/type_signature_validator_checker.sv */
`timescale 1ns / 100ps
// Checker for the type signature validator: watches both channels, tracks the
// open containers of each signature and compares every result transfer.
// Depends on tsv_pkg for status codes, frame kinds and character codes.
module type_signature_validator_checker #(
  parameter int STACK_DEPTH = tsv_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_sig_char,
  input  logic       in_end_of_signature,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_status,
  input  logic [5:0] out_open_depth,
  output int         fail_count,
  output int         outstanding
);

  typedef struct packed {
    tsv_pkg::status_t status;
    logic [5:0]       depth;
  } verdict_t;

  verdict_t verdict_q[$];

  // Shadow of the container stack
  tsv_pkg::frame_t frames [STACK_DEPTH];
  int     level;
  logic   sticky_err;
  int     errors = 0;

  function automatic logic basic_code(input logic [7:0] c);
    logic hit;
    case (c)
      tsv_pkg::CH_BYTE, tsv_pkg::CH_BOOL, tsv_pkg::CH_INT16, tsv_pkg::CH_UINT16,
      tsv_pkg::CH_INT32, tsv_pkg::CH_UINT32, tsv_pkg::CH_INT64, tsv_pkg::CH_UINT64,
      tsv_pkg::CH_DOUBLE, tsv_pkg::CH_STRING, tsv_pkg::CH_OBJPATH, tsv_pkg::CH_SIG,
      tsv_pkg::CH_VARIANT: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // A type just finished: pop finished arrays, count it in the first other frame.
  function automatic tsv_pkg::status_t close_finished();
    tsv_pkg::status_t s;
    logic    done;
    s = tsv_pkg::ST_TYPE;
    done = 1'b0;
    while (!done && level > 0) begin
      if (frames[level-1] == tsv_pkg::FR_ARRAY) begin
        level--;
      end else begin
        s = tsv_pkg::ST_PENDING;
        done = 1'b1;
        case (frames[level-1])
          tsv_pkg::FR_STRUCT_EMPTY: frames[level-1] = tsv_pkg::FR_STRUCT_SOME;
          tsv_pkg::FR_DICT_NONE:    frames[level-1] = tsv_pkg::FR_DICT_ONE;
          tsv_pkg::FR_DICT_ONE:     frames[level-1] = tsv_pkg::FR_DICT_TWO;
          default: ;
        endcase
      end
    end
    return s;
  endfunction

  function automatic tsv_pkg::status_t open_frame(input tsv_pkg::frame_t kind);
    tsv_pkg::status_t s;
    if (level >= STACK_DEPTH) begin
      sticky_err = 1'b1;
      s = tsv_pkg::ST_ERROR;
    end else begin
      frames[level] = kind;
      level++;
      s = tsv_pkg::ST_PENDING;
    end
    return s;
  endfunction

  function automatic void track_char(input logic [7:0] c, input logic last,
                                     output tsv_pkg::status_t st,
                                     output logic [5:0] depth);
    tsv_pkg::status_t s;
    tsv_pkg::frame_t  top;
    logic    have_top;
    s = tsv_pkg::ST_ERROR;
    top = tsv_pkg::FR_ARRAY;
    if (!sticky_err) begin
      have_top = level > 0;
      if (have_top) top = frames[level-1];
      if (have_top && top == tsv_pkg::FR_DICT_TWO && c != tsv_pkg::CH_RBRACE) begin
        sticky_err = 1'b1;
      end else if (basic_code(c)) begin
        s = close_finished();
      end else begin
        case (c)
          tsv_pkg::CH_ARRAY:  s = open_frame(tsv_pkg::FR_ARRAY);
          tsv_pkg::CH_LPAREN: s = open_frame(tsv_pkg::FR_STRUCT_EMPTY);
          tsv_pkg::CH_LBRACE: s = open_frame(tsv_pkg::FR_DICT_NONE);
          tsv_pkg::CH_RPAREN: begin
            if (have_top && top == tsv_pkg::FR_STRUCT_SOME) begin
              level--;
              s = close_finished();
            end else begin
              sticky_err = 1'b1;
            end
          end
          tsv_pkg::CH_RBRACE: begin
            if (have_top && top == tsv_pkg::FR_DICT_TWO) begin
              level--;
              s = close_finished();
            end else begin
              sticky_err = 1'b1;
            end
          end
          default: sticky_err = 1'b1;
        endcase
      end
    end
    depth = level[5:0];
    if (last) begin
      st = (sticky_err || level != 0) ? tsv_pkg::ST_ERROR : tsv_pkg::ST_ACCEPT;
      level = 0;
      sticky_err = 1'b0;
    end else begin
      st = s;
    end
  endfunction

  always @(posedge clk) begin : watch
    verdict_t         want;
    verdict_t         got;
    tsv_pkg::status_t st;
    logic [5:0]       dep;
    if (!rst_n) begin
      verdict_q.delete();
      level = 0;
      sticky_err = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual status %0d depth %0d",
                   $time, out_status, out_open_depth);
        end else begin
          want = verdict_q.pop_front();
          if (out_status !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_status);
          end
          if (out_open_depth !== want.depth) begin
            errors++;
            $display("%0t: open_depth mismatch, expected %0d, actual %0d",
                     $time, want.depth, out_open_depth);
          end
        end
      end
      if (in_valid && !in_stall) begin
        track_char(in_sig_char, in_end_of_signature, st, dep);
        got.status = st;
        got.depth = dep;
        verdict_q.push_back(got);
      end
    end
    fail_count <= errors;
    outstanding <= verdict_q.size();
  end

endmodule

/* dv/type_signature_validator_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the type signature validator: builds signatures, drives
// the character channel, paces the result channel and gives the verdict.
// Depends on tsv_pkg, the block and type_signature_validator_checker.
module type_signature_validator_tb;

  localparam int ITEMS       = 950;   // least number of characters to send in all
  localparam int QUIET_LIMIT = 2000;  // cycles without any transfer before giving up
  localparam int DRAIN_CYCLES = 100;  // beyond the longest pop cascade
  localparam int HOLD_START  = 400;   // receiver hold-off window, in cycles
  localparam int HOLD_LEN    = 250;
  localparam int CALM_START  = 2000;  // receiver never stalls in this window
  localparam int CALM_END    = 3500;
  localparam int BURST_FIRST = 300;   // sender never idles for these characters
  localparam int BURST_LAST  = 600;

  // Codes outside the type alphabet
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LOWER_H = 8'h68;
  localparam logic [7:0] CH_ALL_ONES = 8'hFF;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_sig_char;
  logic       in_end_of_signature;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_status;
  logic [5:0] out_open_depth;

  int fail_count;
  int outstanding;

  logic [7:0] sig_buf[$];  // signature being built, sent in order
  int         sent;        // characters transferred so far

  type_signature_validator dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sig_char         (in_sig_char),
    .in_end_of_signature (in_end_of_signature),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_open_depth      (out_open_depth)
  );

  type_signature_validator_checker grammar_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sig_char         (in_sig_char),
    .in_end_of_signature (in_end_of_signature),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_open_depth      (out_open_depth),
    .fail_count          (fail_count),
    .outstanding         (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] pick_basic();
    logic [7:0] c;
    case ($urandom_range(0, 12))
      0:  c = tsv_pkg::CH_BYTE;
      1:  c = tsv_pkg::CH_BOOL;
      2:  c = tsv_pkg::CH_INT16;
      3:  c = tsv_pkg::CH_UINT16;
      4:  c = tsv_pkg::CH_INT32;
      5:  c = tsv_pkg::CH_UINT32;
      6:  c = tsv_pkg::CH_INT64;
      7:  c = tsv_pkg::CH_UINT64;
      8:  c = tsv_pkg::CH_DOUBLE;
      9:  c = tsv_pkg::CH_STRING;
      10: c = tsv_pkg::CH_OBJPATH;
      11: c = tsv_pkg::CH_SIG;
      default: c = tsv_pkg::CH_VARIANT;
    endcase
    return c;
  endfunction

  // Any character, weighted towards the type alphabet
  function automatic logic [7:0] pick_code();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0: c = tsv_pkg::CH_ARRAY;
      1: c = tsv_pkg::CH_LPAREN;
      2: c = tsv_pkg::CH_RPAREN;
      3: c = tsv_pkg::CH_LBRACE;
      4: c = tsv_pkg::CH_RBRACE;
      5: c = CH_LOWER_H;
      6: c = 8'($urandom_range(0, 255));
      default: c = pick_basic();
    endcase
    return c;
  endfunction

  // Append one well-formed complete type. The generator keeps its own view of
  // the open containers so that it knows which closer, if any, is due next.
  task automatic add_type(input int depth_cap, input int len_cap);
    tsv_pkg::frame_t open_q[$];
    int     n;
    int     top;
    logic   closed;
    logic   done;
    n = 0;
    done = 1'b0;
    while (!done) begin
      closed = 1'b1;
      top = open_q.size() - 1;
      if (top >= 0 && open_q[top] == tsv_pkg::FR_DICT_TWO) begin
        sig_buf.push_back(tsv_pkg::CH_RBRACE);
        void'(open_q.pop_back());
      end else if (top >= 0 && open_q[top] == tsv_pkg::FR_STRUCT_SOME &&
                   (n >= len_cap || $urandom_range(0, 2) == 0)) begin
        sig_buf.push_back(tsv_pkg::CH_RPAREN);
        void'(open_q.pop_back());
      end else if (n < len_cap && open_q.size() < depth_cap &&
                   $urandom_range(0, 99) < 40) begin
        closed = 1'b0;
        case ($urandom_range(0, 2))
          0: begin
            sig_buf.push_back(tsv_pkg::CH_ARRAY);
            open_q.push_back(tsv_pkg::FR_ARRAY);
          end
          1: begin
            sig_buf.push_back(tsv_pkg::CH_LPAREN);
            open_q.push_back(tsv_pkg::FR_STRUCT_EMPTY);
          end
          default: begin
            sig_buf.push_back(tsv_pkg::CH_LBRACE);
            open_q.push_back(tsv_pkg::FR_DICT_NONE);
          end
        endcase
      end else begin
        sig_buf.push_back(pick_basic());
      end
      n++;
      // Drop finished arrays; stop at the first container that counts members.
      while (closed && open_q.size() > 0) begin
        top = open_q.size() - 1;
        case (open_q[top])
          tsv_pkg::FR_ARRAY: void'(open_q.pop_back());
          tsv_pkg::FR_STRUCT_EMPTY: begin
            open_q[top] = tsv_pkg::FR_STRUCT_SOME;
            closed = 1'b0;
          end
          tsv_pkg::FR_DICT_NONE: begin
            open_q[top] = tsv_pkg::FR_DICT_ONE;
            closed = 1'b0;
          end
          tsv_pkg::FR_DICT_ONE: begin
            open_q[top] = tsv_pkg::FR_DICT_TWO;
            closed = 1'b0;
          end
          default: closed = 1'b0;
        endcase
      end
      // closed survives only when the whole type has been finished
      if (closed) done = 1'b1;
    end
  endtask

  // Nest arrays and structs around one basic code, 30 to 34 deep, so that the stack
  // stays just short of full, fills exactly or overflows, and long array cascades follow.
  task automatic build_deep();
    int n;
    int structs;
    n = $urandom_range(30, 34);
    structs = 0;
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) begin
        sig_buf.push_back(tsv_pkg::CH_LPAREN);
        structs++;
      end else begin
        sig_buf.push_back(tsv_pkg::CH_ARRAY);
      end
    end
    sig_buf.push_back(pick_basic());
    repeat (structs) sig_buf.push_back(tsv_pkg::CH_RPAREN);
  endtask

  // Break a well-formed signature: overwrite, drop, insert or cut short.
  task automatic damage();
    int idx;
    idx = $urandom_range(0, sig_buf.size() - 1);
    case ($urandom_range(0, 3))
      0: sig_buf[idx] = 8'($urandom_range(0, 255));
      1: if (sig_buf.size() > 1) void'(sig_buf.pop_back());
      2: sig_buf.insert(idx, pick_code());
      default: while (sig_buf.size() > idx + 1) void'(sig_buf.pop_back());
    endcase
  endtask

  // Offer one character and hold it until the transfer happens. Idle first
  // now and then, except in the burst window where the sender never idles.
  task automatic send_char(input logic [7:0] c, input logic last);
    if (!(sent >= BURST_FIRST && sent < BURST_LAST) && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sig_char <= c;
    in_end_of_signature <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Send the built signature, marking its last character
  task automatic send_sig();
    for (int i = 0; i < sig_buf.size(); i++) begin
      send_char(sig_buf[i], i == sig_buf.size() - 1);
    end
  endtask

  // Result side: random stalls, one long hold-off while the sender keeps
  // offering characters, and a calm window with no stalls at all.
  initial begin : result_sink
    int cyc;
    cyc = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
        out_stall <= 1'b1;
      end else if (cyc >= CALM_START && cyc < CALM_END) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 15);
      end
    end
  end

  // Abort when neither channel has moved a transfer for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int shape;
    sent = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sig_char <= CH_NUL;
    in_end_of_signature <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Array of dict entry holding a struct of every basic code but s: accepted
    sig_buf = '{tsv_pkg::CH_ARRAY, tsv_pkg::CH_LBRACE, tsv_pkg::CH_STRING,
                tsv_pkg::CH_LPAREN, tsv_pkg::CH_BYTE, tsv_pkg::CH_BOOL,
                tsv_pkg::CH_INT16, tsv_pkg::CH_UINT16, tsv_pkg::CH_INT32,
                tsv_pkg::CH_UINT32, tsv_pkg::CH_INT64, tsv_pkg::CH_UINT64,
                tsv_pkg::CH_DOUBLE, tsv_pkg::CH_OBJPATH, tsv_pkg::CH_SIG,
                tsv_pkg::CH_VARIANT, tsv_pkg::CH_RPAREN, tsv_pkg::CH_RBRACE};
    send_sig();
    // Empty struct: misplaced closer
    sig_buf = '{tsv_pkg::CH_LPAREN, tsv_pkg::CH_RPAREN};
    send_sig();
    // Third type inside a dict entry, error then held to the end
    sig_buf = '{tsv_pkg::CH_LBRACE, tsv_pkg::CH_INT32, tsv_pkg::CH_INT32,
                tsv_pkg::CH_INT32};
    send_sig();
    // Unknown characters, including both extremes of the field
    sig_buf = '{CH_LOWER_H};
    send_sig();
    sig_buf = '{CH_NUL};
    send_sig();
    sig_buf = '{CH_ALL_ONES};
    send_sig();

    // Mostly well-formed signatures with random content; the rest broken,
    // noise, or nested deep enough to fill the stack.
    while (sent < ITEMS) begin
      shape = $urandom_range(0, 99);
      sig_buf.delete();
      if (shape < 4) begin
        build_deep();
      end else if (shape < 17) begin
        repeat ($urandom_range(1, 6)) sig_buf.push_back(pick_code());
      end else begin
        repeat ($urandom_range(1, 3)) add_type($urandom_range(1, 6), $urandom_range(1, 12));
        if (shape >= 80) damage();
      end
      send_sig();
    end
    in_valid <= 1'b0;

    // Let the checker count the last transfer, then drain
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/tsv_pkg.sv
hdl/tsv_ram.sv
hdl/type_signature_validator.sv
dv/type_signature_validator_checker.sv
dv/type_signature_validator_tb.sv
